FILE: hw/rtl/bfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_pkg
// shared codes and types for the hop distance search block
// ----------------------------------------------------------------------------
package bfs_pkg;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [1:0] CSR_DIRECTION = 2'd0;
   localparam logic [1:0] CSR_CUT_EN    = 2'd1;
   localparam logic [1:0] CSR_CUT_HOPS  = 2'd2;
   localparam logic [1:0] CSR_VCOUNT    = 2'd3;

   localparam logic [1:0] DIR_FWD  = 2'd0;
   localparam logic [1:0] DIR_BWD  = 2'd1;
   localparam logic [1:0] DIR_BOTH = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic        reachable;
      logic [9:0]  distance;
      logic [10:0] reached_count;
      logic [12:0] edge_count;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hw/rtl/bfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module bfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/bfs_hop_distance_cutoff.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_hop_distance_cutoff
// breadth-first hop distances over a stored directed edge table
// ----------------------------------------------------------------------------
// channel  dir  payload
// req_     in   tdata = mode, vertex_a, vertex_b
// rsp_     out  tdata = status, reachable, distance, reached_count, edge_count
// csr_     in   write enable, register index, write data
//
// clear and add edge go from accept through OUT to the result register
// query does one hop ram read (QRD, QWT) before OUT
// a run first sweeps the hop ram, one vertex a cycle, then for every
// dequeued vertex scans all stored edges, a forward and a backward check
// per edge, with a hop ram check (CRD, CHK) for each hit
// after reset the hop ram is swept once, no beat accepted
// one item at a time; the result register holds while rsp_tready is low
// ----------------------------------------------------------------------------
module bfs_hop_distance_cutoff
   import bfs_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] mode, [11:2] vertex_a, [21:12] vertex_b, [23:22] zero
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [2] reachable, [12:3] distance, [23:13] reached_count,
   // [36:24] edge_count, [39:37] zero
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   // state codes
   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_QRD   = 4'd2;
   localparam logic [3:0] S_QWT   = 4'd3;
   localparam logic [3:0] S_SRC   = 4'd4;
   localparam logic [3:0] S_POP   = 4'd5;
   localparam logic [3:0] S_POPW  = 4'd6;
   localparam logic [3:0] S_SCAN  = 4'd7;
   localparam logic [3:0] S_VIS   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_CRD   = 4'd11;
   localparam logic [3:0] S_CHK   = 4'd12;
   localparam logic [3:0] S_RERD  = 4'd13;

   // registers
   logic [3:0]    state_ff, state_in;
   logic [1:0]    dir_ff;
   logic          cut_en_ff;
   logic [9:0]    cut_hops_ff;
   logic [10:0]   vcount_ff;
   logic [CW-1:0] edges_ff, edges_in;
   logic [VW-1:0] sweep_ff, sweep_in;
   logic          run_sweep_ff, run_sweep_in;
   logic [9:0]    va_ff, va_in;
   logic [NW-1:0] qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [NW-1:0] count_ff, count_in;
   logic [VW-1:0] act_ff, act_in;
   logic [10:0]   next_ff, next_in;
   logic [CW-1:0] eidx_ff, eidx_in;
   logic          phase_ff, phase_in;   // 0 forward check, 1 backward check
   logic [VW-1:0] cand_ff, cand_in;
   logic          rvalid_ff, rvalid_in;
   rsp_type       rsp_ff, rsp_in;

   // hop ram entry: reached flag + hop count
   logic          hop_we;
   logic [VW-1:0] hop_wa, hop_ra;
   logic [11:0]   hop_wd, hop_rd;
   logic          et_we;
   logic [EW-1:0] et_wa, et_ra;
   logic [VW-1:0] et_wd, eh_wd, et_rd, eh_rd;
   logic          q_we;
   logic [VW-1:0] q_wa, q_ra, q_wd, q_rd;

   bfs_ram #(.WIDTH(12), .DEPTH(MAX_VERTICES)) u_hop (
      .clock, .wr_en(hop_we), .wr_addr(hop_wa), .wr_data(hop_wd),
      .rd_addr(hop_ra), .rd_data(hop_rd));
   bfs_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_tail (
      .clock, .wr_en(et_we), .wr_addr(et_wa), .wr_data(et_wd),
      .rd_addr(et_ra), .rd_data(et_rd));
   bfs_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_head (
      .clock, .wr_en(et_we), .wr_addr(et_wa), .wr_data(eh_wd),
      .rd_addr(et_ra), .rd_data(eh_rd));
   bfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   // vertex in range check
   function automatic logic vok(input logic [10:0] vc, input logic [10:0] v);
      vok = (v < vc) && ({21'd0, v} < 32'(MAX_VERTICES));
   endfunction

   logic [1:0] req_mode;
   logic [9:0] req_va, req_vb;
   assign req_mode = req_tdata[1:0];
   assign req_va   = req_tdata[11:2];
   assign req_vb   = req_tdata[21:12];

   logic fwd, bwd;
   assign fwd = (dir_ff != DIR_BWD);
   assign bwd = (dir_ff != DIR_FWD);

   // result register frees when taken
   logic out_free;
   assign out_free   = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;

   logic accept;
   assign accept = req_tvalid && req_tready;

   // candidate edge checks in the visit and check states (edge ram data valid in VIS)
   logic          match;
   logic [VW-1:0] far;
   logic          hit_visit;
   logic [10:0]   cand_ext;
   assign cand_ext  = 11'(cand_ff);
   assign hit_visit = !hop_rd[11] && vok(vcount_ff, cand_ext) &&
                      !(cut_en_ff && (next_ff > {1'b0, cut_hops_ff}));

   always_comb begin
      state_in     = state_ff;
      edges_in     = edges_ff;
      sweep_in     = sweep_ff;
      run_sweep_in = run_sweep_ff;
      va_in        = va_ff;
      qhead_in     = qhead_ff;
      qtail_in     = qtail_ff;
      count_in     = count_ff;
      act_in       = act_ff;
      next_in      = next_ff;
      eidx_in      = eidx_ff;
      phase_in     = phase_ff;
      cand_in      = cand_ff;
      rvalid_in    = rvalid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      hop_we = 1'b0; hop_wa = sweep_ff; hop_wd = 12'd0; hop_ra = va_ff[VW-1:0];
      et_we  = 1'b0; et_wa = edges_ff[EW-1:0];
      et_wd  = req_va[VW-1:0]; eh_wd = req_vb[VW-1:0];
      et_ra  = eidx_ff[EW-1:0];
      q_we   = 1'b0; q_wa = qtail_ff[VW-1:0]; q_wd = cand_ff; q_ra = qhead_ff[VW-1:0];
      match  = 1'b0;
      far    = '0;
      unique case (state_ff)
         S_SWEEP: begin
            hop_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (32'(sweep_ff) == MAX_VERTICES - 1) begin
               state_in = run_sweep_ff ? S_SRC : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               va_in    = req_va;
               rsp_in   = '0;
               unique case (req_mode)
                  MODE_CLEAR: begin
                     edges_in  = '0;
                     rsp_in.edge_count = '0;
                     state_in  = S_OUT;
                  end
                  MODE_ADD: begin
                     if (!vok(vcount_ff, {1'b0, req_va}) ||
                         !vok(vcount_ff, {1'b0, req_vb})) begin
                        rsp_in.status = ST_RANGE;
                     end else if (32'(edges_ff) >= MAX_EDGES) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        et_we    = 1'b1;
                        edges_in = edges_ff + 1'b1;
                     end
                     rsp_in.edge_count = 13'(edges_in);
                     state_in = S_OUT;
                  end
                  MODE_RUN: begin
                     rsp_in.edge_count = 13'(edges_ff);
                     if (!vok(vcount_ff, {1'b0, req_va})) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_OUT;
                     end else begin
                        sweep_in     = '0;
                        run_sweep_in = 1'b1;
                        state_in     = S_SWEEP;
                     end
                  end
                  MODE_QUERY: begin
                     rsp_in.edge_count = 13'(edges_ff);
                     if (!vok(vcount_ff, {1'b0, req_va})) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_OUT;
                     end else begin
                        state_in = S_QRD;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_QRD: state_in = S_QWT;   // hop read issued on va
         S_QWT: begin
            rsp_in.reachable = hop_rd[11];
            rsp_in.distance  = hop_rd[11] ? hop_rd[9:0] : 10'd0;
            state_in = S_OUT;
         end
         S_SRC: begin
            // source is always reached at hop 0
            run_sweep_in = 1'b0;
            hop_we   = 1'b1;
            hop_wa   = va_ff[VW-1:0];
            hop_wd   = 12'h800;
            q_we     = 1'b1;
            q_wa     = '0;
            q_wd     = va_ff[VW-1:0];
            qhead_in = '0;
            qtail_in = NW'(1);
            count_in = NW'(1);
            state_in = S_POP;
         end
         S_POP: begin
            if (qhead_ff == qtail_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            // queue data for head now valid; fetch its hop
            act_in   = q_rd;
            qhead_in = qhead_ff + 1'b1;
            hop_ra   = q_rd;
            eidx_in  = '0;
            phase_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // first cycle after POPW: hop_rd is act's hop; later: edge data
            if (eidx_ff >= edges_ff) begin
               state_in = S_POP;
            end else begin
               et_ra    = eidx_ff[EW-1:0];
               state_in = S_VIS;
               phase_in = 1'b0;
            end
         end
         S_VIS: begin
            // edge data valid; pick the neighbor for this phase
            if (!phase_ff) begin
               match = fwd && (et_rd == act_ff);
               far   = eh_rd;
            end else begin
               match = bwd && (eh_rd == act_ff);
               far   = et_rd;
            end
            et_ra = eidx_ff[EW-1:0];
            if (match) begin
               cand_in  = far;
               hop_ra   = far;
               state_in = S_CRD;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_CRD: begin
            // keep the candidate address on the hop ram for the check cycle
            hop_ra   = cand_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (hit_visit) begin
               hop_we   = 1'b1;
               hop_wa   = cand_ff;
               hop_wd   = {1'b1, next_ff};
               count_in = count_ff + 1'b1;
               if (32'(qtail_ff) < MAX_VERTICES) begin
                  q_we     = 1'b1;
                  qtail_in = qtail_ff + 1'b1;
               end
            end
            et_ra = eidx_ff[EW-1:0];
            if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = S_RERD;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_RERD: state_in = S_VIS;   // edge reread for backward phase
         S_DONE: begin
            rsp_in.reached_count = 11'(count_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hop of the dequeued vertex, plus one: captured into next_ff in the cycle after the POPW read
   logic popw_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         run_sweep_ff <= 1'b0;
         edges_ff     <= '0;
         rvalid_ff    <= 1'b0;
         dir_ff       <= '0;
         cut_en_ff    <= 1'b0;
         cut_hops_ff  <= '0;
         vcount_ff    <= 11'd1024;
         qhead_ff     <= '0;
         qtail_ff     <= '0;
         popw_d_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         run_sweep_ff <= run_sweep_in;
         edges_ff     <= edges_in;
         rvalid_ff    <= rvalid_in;
         qhead_ff     <= qhead_in;
         qtail_ff     <= qtail_in;
         popw_d_ff    <= (state_ff == S_POPW);
         if (csr_wen) begin
            unique case (csr_index)
               CSR_DIRECTION: dir_ff      <= csr_wdata[1:0];
               CSR_CUT_EN:    cut_en_ff   <= csr_wdata[0];
               CSR_CUT_HOPS:  cut_hops_ff <= csr_wdata[9:0];
               CSR_VCOUNT:    vcount_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
      va_ff    <= va_in;
      count_ff <= count_in;
      act_ff   <= act_in;
      next_ff  <= popw_d_ff ? {1'b0, hop_rd[9:0]} + 11'd1 : next_in;
      eidx_ff  <= eidx_in;
      phase_ff <= phase_in;
      cand_ff  <= cand_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {3'd0, rsp_ff.edge_count, rsp_ff.reached_count,
                        rsp_ff.distance, rsp_ff.reachable, rsp_ff.status};

   // assertions
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      qhead_ff <= qtail_ff) else $error("queue head passed tail");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      32'(edges_ff) <= MAX_EDGES) else $error("edge count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
endmodule
`default_nettype wire
